// ----- sv/jbdi_pkg.sv -----
package jbdi_pkg;

  localparam int NUM_COMPONENTS_DEF  = 4;
  localparam int BASIS_FRAC_BITS_DEF = 14;

  // Datapath widths, sized for the widest basis (16 fraction bits).
  localparam int COEF_W  = 24;
  localparam int BASIS_W = 18;
  localparam int M1_W    = COEF_W + BASIS_W;
  localparam int M2_W    = M1_W + BASIS_W;
  localparam int ACC_W   = M2_W + 6;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_DC    = 2'd1;
  localparam logic [1:0] ACT_AC    = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CALC,
    ST_DRAIN
  } state_t;

  // One MAC term in flight: pixel (y, x) and frequency pair (v, u).
  typedef struct packed {
    logic       vld;
    logic [2:0] y;
    logic [2:0] x;
    logic [2:0] v;
    logic [2:0] u;
  } term_t;

  typedef logic [63:0][BASIS_W-1:0] basis_arr_t;

  // cos(k*pi/16) scaled, in millionths, row = frequency, column = position
  localparam int BASIS_MICRO [64] = '{
     707107,  707107,  707107,  707107,  707107,  707107,  707107,  707107,
     980785,  831470,  555570,  195090, -195090, -555570, -831470, -980785,
     923880,  382683, -382683, -923880, -923880, -382683,  382683,  923880,
     831470, -195090, -980785, -555570,  555570,  980785,  195090, -831470,
     707107, -707107, -707107,  707107,  707107, -707107, -707107,  707107,
     555570, -980785,  195090,  831470, -831470, -195090,  980785, -555570,
     382683, -923880,  923880, -382683, -382683,  923880, -923880,  382683,
     195090, -555570,  831470, -980785,  980785, -831470,  555570, -195090
  };

  // zigzag position of coefficient [v][u]
  localparam logic [5:0] ZZ_POS [64] = '{
     0,  1,  5,  6, 14, 15, 27, 28,
     2,  4,  7, 13, 16, 26, 29, 42,
     3,  8, 12, 17, 25, 30, 41, 43,
     9, 11, 18, 24, 31, 40, 44, 53,
    10, 19, 23, 32, 39, 45, 52, 54,
    20, 22, 33, 38, 46, 51, 55, 60,
    21, 34, 37, 47, 50, 56, 59, 61,
    35, 36, 48, 49, 57, 58, 62, 63
  };

  // Round each magnitude half up, then restore the sign.
  function automatic basis_arr_t basis_table(input int frac);
    basis_arr_t t;
    longint     a;
    longint     q;
    for (int i = 0; i < 64; i++) begin
      a = (BASIS_MICRO[i] < 0) ? -longint'(BASIS_MICRO[i]) : longint'(BASIS_MICRO[i]);
      q = ((a << frac) + 64'sd500000) / 64'sd1000000;
      t[i] = BASIS_W'((BASIS_MICRO[i] < 0) ? -q : q);
    end
    return t;
  endfunction

  // Sign-extend JPEG magnitude bits of the given size (1..16), modulo 2^16.
  function automatic logic [15:0] extend_bits(input logic [15:0] bits,
                                              input logic [4:0] size);
    logic [15:0] mask;
    logic [15:0] b;
    mask = 16'((17'd1 << size) - 17'd1);
    b    = bits & mask;
    return bits[4'(size - 5'd1)] ? b : 16'(b - mask);
  endfunction

endpackage

// ----- sv/jbdi_if.sv -----
interface jbdi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [1:0]  component;
  logic [7:0]  symbol;
  logic [15:0] extra_bits;
  logic [5:0]  table_index;
  logic [7:0]  table_value;

  modport source(output valid, action, component, symbol, extra_bits, table_index,
                 table_value, input ready);
  modport sink(input valid, action, component, symbol, extra_bits, table_index,
               table_value, output ready);
endinterface

interface jbdi_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] pix_row;
  logic [2:0] pix_col;
  logic [7:0] pix_value;
  logic [1:0] pix_component;
  logic       last_pixel;

  modport source(output valid, pix_row, pix_col, pix_value, pix_component, last_pixel,
                 input ready);
  modport sink(input valid, pix_row, pix_col, pix_value, pix_component, last_pixel,
               output ready);
endinterface

// ----- sv/jpeg_block_dequant_idct.sv -----
// Channel   Dir  Payload                                                  Moves per item
// in_ch     in   action, component, symbol, extra_bits, table_index/value  one symbol/load
// out_ch    out  pix_row, pix_col, pix_value, pix_component, last_pixel   one pixel
//
// Symbols: a load, a predictor clear or an ignored item is taken in ST_IDLE; a DC symbol or an
// AC coefficient then also passes through ST_MUL (quant table read, then multiply and write to coef RAM).
// Block end: a direct 8x8 IDCT on one shared MAC, 64 terms per pixel, swept term by term
// through the MAC pipeline; no symbol is taken until the last pixel leaves.
// Reset (rst, synchronous) zeroes predictors, position and coefficient valid bits; the
// quant table has no reset. A stalled out_ch freezes the whole MAC pipeline.
module jpeg_block_dequant_idct #(
  parameter int NUM_COMPONENTS  = jbdi_pkg::NUM_COMPONENTS_DEF,
  parameter int BASIS_FRAC_BITS = jbdi_pkg::BASIS_FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  jbdi_in_if.sink    in_ch,
  jbdi_out_if.source out_ch
);

  localparam int QA_W  = $clog2(NUM_COMPONENTS * 64);
  localparam int CI_W  = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam int CW    = jbdi_pkg::COEF_W;
  localparam int BW    = jbdi_pkg::BASIS_W;
  localparam int M1W   = jbdi_pkg::M1_W;
  localparam int M2W   = jbdi_pkg::M2_W;
  localparam int AW    = jbdi_pkg::ACC_W;
  localparam int SH    = 2 * BASIS_FRAC_BITS + 2;
  localparam jbdi_pkg::basis_arr_t BASIS = jbdi_pkg::basis_table(BASIS_FRAC_BITS);

  // ---------------------------------------------------------------- storage
  logic [7:0]    qmem [NUM_COMPONENTS * 64];
  logic [CW-1:0] cmem [64];
  logic [63:0]   cvalid;                        // entry not written since DC reads zero
  logic [15:0]   dc_pred [NUM_COMPONENTS];

  jbdi_pkg::state_t state, state_next;
  logic [6:0]       coef_pos;
  logic [1:0]       active_comp;
  logic [7:0]       q_rdata;
  logic [15:0]      mul_val;
  logic [5:0]       mul_addr;
  logic             end_pend;
  logic [11:0]      cnt;

  // ---------------------------------------------------------------- decode
  logic            take, comp_ok;
  logic [3:0]      ac_size, ac_run;
  logic [6:0]      pos_run, pos_zrl;
  logic [4:0]      dc_size;
  logic [15:0]     dc_diff, dc_new;
  logic [CI_W-1:0] cidx;
  logic [QA_W-1:0] q_raddr;
  logic            do_load, do_clear, do_dc, ac_live, ac_write, ac_end, ac_skip;
  logic            issue, pipe_en, out_take;
  logic            fire;

  always_comb begin
    take     = in_ch.valid && in_ch.ready;
    comp_ok  = {1'b0, in_ch.component} < 3'(NUM_COMPONENTS);
    cidx     = CI_W'(in_ch.component);
    ac_size  = in_ch.symbol[3:0];
    ac_run   = in_ch.symbol[7:4];
    pos_run  = coef_pos + 7'(ac_run);
    pos_zrl  = coef_pos + 7'd16;
    dc_size  = (in_ch.symbol > 8'd16) ? 5'd16 : in_ch.symbol[4:0];
    dc_diff  = (dc_size == 5'd0) ? 16'd0 : jbdi_pkg::extend_bits(in_ch.extra_bits, dc_size);
    dc_new   = dc_pred[cidx] + dc_diff;
    do_load  = take && in_ch.action == jbdi_pkg::ACT_LOAD  && comp_ok;
    do_clear = take && in_ch.action == jbdi_pkg::ACT_CLEAR && comp_ok;
    do_dc    = take && in_ch.action == jbdi_pkg::ACT_DC    && comp_ok;
    // an AC symbol only counts inside a block
    ac_live  = take && in_ch.action == jbdi_pkg::ACT_AC && coef_pos != 7'd0;
    ac_write = ac_live && ac_size != 4'd0 && pos_run < 7'd64;
    ac_skip  = ac_live && ac_size == 4'd0 && ac_run == 4'hf && pos_zrl < 7'd64;
    // EOB, a ZRL that reaches the end, or a write past the last position
    ac_end   = ac_live && !ac_write && !ac_skip;
    q_raddr  = do_dc ? QA_W'({in_ch.component, 6'd0})
                     : QA_W'({active_comp, pos_run[5:0]});
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    unique case (state)
      jbdi_pkg::ST_IDLE: begin
        if (do_dc || ac_write) state_next = jbdi_pkg::ST_MUL;
        else if (ac_end)       state_next = jbdi_pkg::ST_CALC;
      end
      jbdi_pkg::ST_MUL:   state_next = end_pend ? jbdi_pkg::ST_CALC : jbdi_pkg::ST_IDLE;
      jbdi_pkg::ST_CALC: begin
        if (pipe_en && cnt == 12'hfff) state_next = jbdi_pkg::ST_DRAIN;
      end
      jbdi_pkg::ST_DRAIN: begin
        if (out_take && out_ch.last_pixel) state_next = jbdi_pkg::ST_IDLE;
      end
      default: state_next = jbdi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = state == jbdi_pkg::ST_IDLE;
    fire        = state == jbdi_pkg::ST_MUL;
    issue       = state == jbdi_pkg::ST_CALC;
    pipe_en     = !out_ch.valid || out_ch.ready;
    out_take    = out_ch.valid && out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= jbdi_pkg::ST_IDLE;
      coef_pos    <= '0;
      active_comp <= '0;
      cvalid      <= '0;
      end_pend    <= 1'b0;
      cnt         <= '0;
      for (int i = 0; i < NUM_COMPONENTS; i++) dc_pred[i] <= '0;
    end else begin
      state <= state_next;
      if (do_clear) dc_pred[cidx] <= '0;
      if (do_dc) begin
        dc_pred[cidx] <= dc_new;
        cvalid        <= '0;
        active_comp   <= in_ch.component;
        coef_pos      <= 7'd1;
        end_pend      <= 1'b0;
      end
      if (ac_write) begin
        end_pend <= pos_run == 7'd63;
        coef_pos <= (pos_run == 7'd63) ? 7'd0 : pos_run + 7'd1;
      end
      if (ac_skip) coef_pos <= pos_zrl;
      if (ac_end)  coef_pos <= 7'd0;
      if (fire)    cvalid[mul_addr] <= 1'b1;
      // sweep pixel by pixel; restart from zero for every block
      if (!issue)        cnt <= '0;
      else if (pipe_en)  cnt <= cnt + 12'd1;
    end
  end

  // quant table: written by loads, read in the cycle before the multiply
  always_ff @(posedge clk) begin
    if (do_load) qmem[QA_W'({in_ch.component, in_ch.table_index})] <= in_ch.table_value;
    q_rdata <= qmem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (do_dc) begin
      mul_val  <= dc_new;
      mul_addr <= '0;
    end else if (ac_write) begin
      mul_val  <= jbdi_pkg::extend_bits(in_ch.extra_bits, {1'b0, ac_size});
      mul_addr <= pos_run[5:0];
    end
  end

  // dequantize and store the coefficient
  always_ff @(posedge clk) begin
    if (fire) cmem[mul_addr] <= CW'($signed(mul_val) * $signed({1'b0, q_rdata}));
  end

  // ---------------------------------------------------------------- MAC pipeline
  jbdi_pkg::term_t          ta, tb, tc, td;
  logic [5:0]               a_addr;
  logic [CW-1:0]            coef_b;
  logic                     cv_b;
  logic signed [M1W-1:0]    m1;
  logic signed [M2W-1:0]    m2;
  logic signed [AW-1:0]     acc;
  logic                     ve, vf, vg;
  logic [5:0]               pe, pf, pg;       // {y, x} of the finished pixel
  logic [AW-1:0]            mag, rsum, rm;
  logic                     nf, ng;
  logic                     d_first, d_last;
  logic [7:0]               pix_next;
  logic                     big;

  always_comb begin
    d_first = td.v == 3'd0 && td.u == 3'd0;
    d_last  = td.v == 3'd7 && td.u == 3'd7;
    rm      = rsum >> SH;
    big     = |(rm >> 7);
    if (ng) pix_next = big ? 8'd0   : 8'(9'd128 - {2'b0, rm[6:0]});
    else    pix_next = big ? 8'd255 : 8'(9'd128 + {2'b0, rm[6:0]});
  end

  // term tags: issue with the sweep counter, then advance one stage per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      ta           <= '0;
      tb           <= '0;
      tc           <= '0;
      td           <= '0;
      ve           <= 1'b0;
      vf           <= 1'b0;
      vg           <= 1'b0;
      out_ch.valid <= 1'b0;
    end else if (pipe_en) begin
      ta           <= {issue, cnt};
      tb           <= ta;
      tc           <= tb;
      td           <= tc;
      ve           <= td.vld && d_last;
      vf           <= ve;
      vg           <= vf;
      out_ch.valid <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      // issue: coefficient address of term (v, u)
      a_addr <= jbdi_pkg::ZZ_POS[cnt[5:0]];
      // coefficient read
      coef_b <= cmem[a_addr];
      cv_b   <= cvalid[a_addr];
      // horizontal basis
      m1 <= $signed(cv_b ? coef_b : CW'(0)) * $signed(BASIS[{tb.u, tb.x}]);
      // vertical basis
      m2 <= m1 * $signed(BASIS[{tc.v, tc.y}]);
      // accumulate; the first term of a pixel restarts the sum
      if (td.vld) acc <= d_first ? AW'(m2) : acc + AW'(m2);
      pe <= {td.y, td.x};
      // magnitude, then round half away from zero
      mag  <= acc[AW-1] ? AW'(-acc) : AW'(acc);
      nf   <= acc[AW-1];
      pf   <= pe;
      rsum <= mag + (AW'(1) << (SH - 1));
      ng   <= nf;
      pg   <= pf;
      // level shift and clamp into the output register
      out_ch.pix_value     <= pix_next;
      out_ch.pix_row       <= pg[5:3];
      out_ch.pix_col       <= pg[2:0];
      out_ch.pix_component <= active_comp;
      out_ch.last_pixel    <= pg == 6'h3f;
    end
  end

`ifndef SYNTHESIS
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == jbdi_pkg::ST_IDLE |-> !out_ch.valid)
    else $error("pixel pending while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && out_ch.last_pixel |=> state == jbdi_pkg::ST_IDLE)
    else $error("block did not end on last pixel");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    coef_pos < 7'd64)
    else $error("coefficient position out of range");
`endif

endmodule
